// ----- rtl/tun_pkg.sv -----
// Shared types and constants for the triangle unit normal pipeline.
// Depends on nothing; every rtl module imports it.
package tun_pkg;

  // Field and datapath widths
  localparam int COORD_W = 16;              // vertex coordinate, Q8.8
  localparam int FRAC_W  = 14;              // normal fraction bits, Q1.14
  localparam int OUT_W   = 16;              // normal field width
  localparam int EDGE_W  = COORD_W + 1;     // exact edge difference
  localparam int PROD_W  = 2 * EDGE_W;      // one cross-product term
  localparam int CROSS_W = PROD_W + 1;      // signed cross component
  localparam int MAG_W   = PROD_W;          // cross component magnitude
  localparam int M_W     = 31;              // magnitude after normalize shift
  localparam int SH_MAX  = MAG_W - M_W;     // largest normalize shift
  localparam int SH_W    = $clog2(SH_MAX + 1);
  localparam int SQ_W    = 2 * M_W;         // one square
  localparam int SUM_W   = 64;              // sum of three squares
  localparam int ROOT_W  = SUM_W / 2;       // integer square root
  localparam int Q_W     = FRAC_W + 1;      // quotient bits, q <= 2^FRAC_W
  localparam int DEN_W   = ROOT_W + 1;      // 2 * length
  localparam int NUM_W   = M_W + Q_W + 2;   // rounded dividend

  // Input word: one triangle
  typedef struct packed {
    logic signed [COORD_W-1:0] vert_a_x;
    logic signed [COORD_W-1:0] vert_a_y;
    logic signed [COORD_W-1:0] vert_a_z;
    logic signed [COORD_W-1:0] vert_b_x;
    logic signed [COORD_W-1:0] vert_b_y;
    logic signed [COORD_W-1:0] vert_b_z;
    logic signed [COORD_W-1:0] vert_c_x;
    logic signed [COORD_W-1:0] vert_c_y;
    logic signed [COORD_W-1:0] vert_c_z;
  } tun_in_t;

  // Result word: unit normal
  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    degenerate;
  } tun_out_t;

  // Data that rides along with the sum through the square root
  typedef struct packed {
    logic [2:0][M_W-1:0] mag;
    logic [2:0]          neg;
    logic                deg;
  } tun_side_t;

  // Per-component flags that ride through a divider
  typedef struct packed {
    logic neg;
    logic deg;
  } tun_flag_t;

endpackage

// ----- rtl/triangle_unit_normal_top.sv -----
// Throughput: one triangle per cycle.
// Path: 7 front-end stages; 33 square-root stages (input register, then one root bit each);
// 16 divider stages (input register, then one quotient bit each); 1 output register.
// busy is always low: the pipeline never stalls and the receiver cannot stall.
// Reset (rst_n low, synchronous) clears all valid bits; data is not cleared.
module triangle_unit_normal_top
  import tun_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  tun_in_t  in_word,
  output logic     out_valid,
  output tun_out_t out_word
);

  logic              f_vld, s_vld;
  logic [SUM_W-1:0]  f_sum;
  tun_side_t         f_side, s_side;
  logic [ROOT_W-1:0] s_root;
  logic [2:0]        d_vld;
  logic signed [OUT_W-1:0] d_norm [3];
  logic              deg_q [Q_W+1];
  logic              out_valid_r;
  tun_out_t          out_word_r;

  assign busy = 1'b0;

  tun_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start),
    .in_word (in_word),
    .out_vld (f_vld),
    .out_sum (f_sum),
    .out_side(f_side)
  );

  tun_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (f_vld),
    .in_sum  (f_sum),
    .in_side (f_side),
    .out_vld (s_vld),
    .out_root(s_root),
    .out_side(s_side)
  );

  // One divider per component
  for (genvar i = 0; i < 3; i++) begin : g_div
    tun_flag_t flg;
    assign flg.neg = s_side.neg[i];
    assign flg.deg = s_side.deg;
    tun_div u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (s_vld),
      .in_mag  (s_side.mag[i]),
      .in_len  (s_root),
      .in_flag (flg),
      .out_vld (d_vld[i]),
      .out_norm(d_norm[i])
    );
  end

  // Delay the degenerate flag alongside the dividers
  always_ff @(posedge clk) begin
    deg_q[0] <= s_side.deg;
    for (int k = 0; k < Q_W; k++) deg_q[k+1] <= deg_q[k];
  end

  // Register the result word
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= d_vld[0];
  end
  always_ff @(posedge clk) begin
    out_word_r.normal_x   <= d_norm[0];
    out_word_r.normal_y   <= d_norm[1];
    out_word_r.normal_z   <= d_norm[2];
    out_word_r.degenerate <= deg_q[Q_W];
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Degenerate word carries a zero normal
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.degenerate |->
      out_word.normal_x == '0 && out_word.normal_y == '0 && out_word.normal_z == '0)
    else $error("degenerate word with nonzero normal");

  // Good word has at least one nonzero component
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.degenerate |->
      out_word.normal_x != '0 || out_word.normal_y != '0 || out_word.normal_z != '0)
    else $error("nondegenerate word with zero normal");

  // X component stays within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_word.normal_x <= $signed(OUT_W'(1) << FRAC_W)) &&
      (out_word.normal_x >= -$signed(OUT_W'(1) << FRAC_W)))
    else $error("normal x out of range");

  // Dividers stay in lockstep
  a_lock: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld[0] == d_vld[1] && d_vld[1] == d_vld[2])
    else $error("divider valid bits diverged");

endmodule

// ----- rtl/tun_front.sv -----
// Front end: edges, cross product, magnitude scaling and sum of squares.
// Seven register stages. Depends on tun_pkg.
module tun_front
  import tun_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  tun_in_t   in_word,
  output logic      out_vld,
  output logic [SUM_W-1:0] out_sum,
  output tun_side_t out_side
);

  logic                     v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] e2_r [3];
  logic signed [PROD_W-1:0] pr_r [6];
  logic [2:0][MAG_W-1:0]    mag3_r, mag4_r;
  logic [2:0]               neg3_r, neg4_r, neg5_r, neg6_r, neg7_r;
  logic [SH_W-1:0]          sh4_r;
  logic                     deg4_r, deg5_r, deg6_r, deg7_r;
  logic [2:0][M_W-1:0]      m5_r, m6_r, m7_r;
  logic [SQ_W-1:0]          sq6_r [3];
  logic [SUM_W-1:0]         sum7_r;

  logic signed [CROSS_W-1:0] cr [3];
  logic [MAG_W-1:0]          big;
  logic [SH_W-1:0]           sh_nxt;

  // Cross components from the registered products
  always_comb begin
    cr[0] = CROSS_W'(pr_r[0]) - CROSS_W'(pr_r[1]);
    cr[1] = CROSS_W'(pr_r[2]) - CROSS_W'(pr_r[3]);
    cr[2] = CROSS_W'(pr_r[4]) - CROSS_W'(pr_r[5]);
  end

  // Largest magnitude and the smallest shift that brings it below 2^M_W
  always_comb begin
    big = mag3_r[0];
    if (mag3_r[1] > big) big = mag3_r[1];
    if (mag3_r[2] > big) big = mag3_r[2];
    sh_nxt = '0;
    for (int k = SH_MAX; k >= 0; k--) begin
      if ((big >> k) < (MAG_W'(1) << M_W)) sh_nxt = SH_W'(k);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
    end else begin
      v1_r <= in_vld; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r;   v6_r <= v5_r; v7_r <= v6_r;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    // edges
    e1_r[0] <= EDGE_W'(in_word.vert_a_x) - EDGE_W'(in_word.vert_b_x);
    e1_r[1] <= EDGE_W'(in_word.vert_a_y) - EDGE_W'(in_word.vert_b_y);
    e1_r[2] <= EDGE_W'(in_word.vert_a_z) - EDGE_W'(in_word.vert_b_z);
    e2_r[0] <= EDGE_W'(in_word.vert_b_x) - EDGE_W'(in_word.vert_c_x);
    e2_r[1] <= EDGE_W'(in_word.vert_b_y) - EDGE_W'(in_word.vert_c_y);
    e2_r[2] <= EDGE_W'(in_word.vert_b_z) - EDGE_W'(in_word.vert_c_z);
    // products
    pr_r[0] <= e1_r[1] * e2_r[2];
    pr_r[1] <= e1_r[2] * e2_r[1];
    pr_r[2] <= e1_r[2] * e2_r[0];
    pr_r[3] <= e1_r[0] * e2_r[2];
    pr_r[4] <= e1_r[0] * e2_r[1];
    pr_r[5] <= e1_r[1] * e2_r[0];
    // magnitudes and signs
    for (int i = 0; i < 3; i++) begin
      neg3_r[i] <= cr[i][CROSS_W-1];
      mag3_r[i] <= cr[i][CROSS_W-1] ? MAG_W'(-cr[i]) : MAG_W'(cr[i]);
    end
    // shift select
    mag4_r <= mag3_r;
    neg4_r <= neg3_r;
    sh4_r  <= sh_nxt;
    deg4_r <= (big == '0);
    // apply shift
    for (int i = 0; i < 3; i++) m5_r[i] <= M_W'(mag4_r[i] >> sh4_r);
    neg5_r <= neg4_r;
    deg5_r <= deg4_r;
    // squares
    for (int i = 0; i < 3; i++) sq6_r[i] <= SQ_W'(m5_r[i]) * SQ_W'(m5_r[i]);
    m6_r   <= m5_r;
    neg6_r <= neg5_r;
    deg6_r <= deg5_r;
    // sum
    sum7_r <= SUM_W'(sq6_r[0]) + SUM_W'(sq6_r[1]) + SUM_W'(sq6_r[2]);
    m7_r   <= m6_r;
    neg7_r <= neg6_r;
    deg7_r <= deg6_r;
  end

  assign out_vld       = v7_r;
  assign out_sum       = sum7_r;
  assign out_side.mag  = m7_r;
  assign out_side.neg  = neg7_r;
  assign out_side.deg  = deg7_r;

endmodule

// ----- rtl/tun_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Depends on tun_pkg.
module tun_sqrt
  import tun_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [SUM_W-1:0]  in_sum,
  input  tun_side_t         in_side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output tun_side_t         out_side
);

  logic [ROOT_W:0]    vld_r;
  logic [SUM_W-1:0]   rem_r  [ROOT_W+1];
  logic [SUM_W-1:0]   root_r [ROOT_W+1];
  tun_side_t          side_r [ROOT_W+1];

  // Stage zero holds the incoming word
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_vld;
  end
  always_ff @(posedge clk) begin
    rem_r[0]  <= in_sum;
    root_r[0] <= '0;
    side_r[0] <= in_side;
  end

  // One digit step per stage
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_W - 1 - i));
    logic [SUM_W-1:0] trial;
    assign trial = root_r[i] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else        vld_r[i+1] <= vld_r[i];
    end

    always_ff @(posedge clk) begin
      if (rem_r[i] >= trial) begin
        rem_r[i+1]  <= rem_r[i] - trial;
        root_r[i+1] <= (root_r[i] >> 1) + BIT;
      end else begin
        rem_r[i+1]  <= rem_r[i];
        root_r[i+1] <= root_r[i] >> 1;
      end
      side_r[i+1] <= side_r[i];
    end
  end

  assign out_vld  = vld_r[ROOT_W];
  assign out_root = ROOT_W'(root_r[ROOT_W]);
  assign out_side = side_r[ROOT_W];

endmodule

// ----- rtl/tun_div.sv -----
// Pipelined restoring divider: rounded magnitude over length, one quotient
// bit per stage, then clamp and sign. Depends on tun_pkg.
module tun_div
  import tun_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic [M_W-1:0]          in_mag,
  input  logic [ROOT_W-1:0]       in_len,
  input  tun_flag_t               in_flag,
  output logic                    out_vld,
  output logic signed [OUT_W-1:0] out_norm
);

  localparam logic [Q_W-1:0] Q_LIM = Q_W'(1) << FRAC_W;

  logic [Q_W:0]     vld_r;
  logic [NUM_W-1:0] rem_r [Q_W+1];
  logic [DEN_W-1:0] den_r [Q_W+1];
  logic [Q_W-1:0]   q_r   [Q_W+1];
  tun_flag_t        flg_r [Q_W+1];

  logic [ROOT_W-1:0] len;
  logic [Q_W-1:0]    q_sat;

  // Treat a zero length as one
  assign len = (in_len == '0) ? ROOT_W'(1) : in_len;

  // Form dividend and divisor
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_vld;
  end
  always_ff @(posedge clk) begin
    rem_r[0] <= (NUM_W'(in_mag) << (FRAC_W + 1)) + NUM_W'(len);
    den_r[0] <= {len, 1'b0};
    q_r[0]   <= '0;
    flg_r[0] <= in_flag;
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int BP = Q_W - 1 - j;
    logic [NUM_W-1:0] sub;
    assign sub = NUM_W'(den_r[j]) << BP;

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[j+1] <= 1'b0;
      else        vld_r[j+1] <= vld_r[j];
    end

    always_ff @(posedge clk) begin
      if (rem_r[j] >= sub) begin
        rem_r[j+1] <= rem_r[j] - sub;
        q_r[j+1]   <= q_r[j] | (Q_W'(1) << BP);
      end else begin
        rem_r[j+1] <= rem_r[j];
        q_r[j+1]   <= q_r[j];
      end
      den_r[j+1] <= den_r[j];
      flg_r[j+1] <= flg_r[j];
    end
  end

  // Clamp, then apply sign; degenerate forces zero
  always_comb begin
    q_sat = (q_r[Q_W] > Q_LIM) ? Q_LIM : q_r[Q_W];
    if (flg_r[Q_W].deg)      out_norm = '0;
    else if (flg_r[Q_W].neg) out_norm = -OUT_W'(q_sat);
    else                     out_norm = OUT_W'(q_sat);
  end

  assign out_vld = vld_r[Q_W];

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for triangle_unit_normal_top: drives random and corner triangles and
// checks each unit normal against an integer predictor. Depends on tun_pkg.
module tb_top;
  import tun_pkg::*;

  // Expected-normal store with predictor
  class normal_board;
    tun_out_t pending[$];
    int errors;

    function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] rem, root, b;
      rem = v;
      root = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
        if (rem >= root + b) begin
          rem = rem - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    function automatic tun_out_t unit_normal(tun_in_t t);
      longint e1[3], e2[3], p[3];
      logic [63:0] m[3], big, sum, len, num, q, lim;
      int s;
      tun_out_t r;
      e1[0] = longint'(t.vert_a_x) - longint'(t.vert_b_x);
      e1[1] = longint'(t.vert_a_y) - longint'(t.vert_b_y);
      e1[2] = longint'(t.vert_a_z) - longint'(t.vert_b_z);
      e2[0] = longint'(t.vert_b_x) - longint'(t.vert_c_x);
      e2[1] = longint'(t.vert_b_y) - longint'(t.vert_c_y);
      e2[2] = longint'(t.vert_b_z) - longint'(t.vert_c_z);
      p[0] = e1[1] * e2[2] - e1[2] * e2[1];
      p[1] = e1[2] * e2[0] - e1[0] * e2[2];
      p[2] = e1[0] * e2[1] - e1[1] * e2[0];
      r = '0;
      for (int i = 0; i < 3; i++) m[i] = p[i] < 0 ? -p[i] : p[i];
      if (m[0] == 0 && m[1] == 0 && m[2] == 0) begin
        r.degenerate = 1'b1;
        return r;
      end
      big = m[0];
      if (m[1] > big) big = m[1];
      if (m[2] > big) big = m[2];
      s = 0;
      while ((big >> s) >= 64'h8000_0000) s++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = m[i] >> s;
        sum = sum + m[i] * m[i];
      end
      len = isqrt(sum);
      if (len == 0) len = 1;
      lim = 64'd1 << FRAC_W;
      for (int i = 0; i < 3; i++) begin
        num = (m[i] << FRAC_W) * 2 + len;
        q = num / (2 * len);
        if (q > lim) q = lim;
        if (p[i] < 0) q = -q;
        case (i)
          0: r.normal_x = q[OUT_W-1:0];
          1: r.normal_y = q[OUT_W-1:0];
          default: r.normal_z = q[OUT_W-1:0];
        endcase
      end
      return r;
    endfunction

    function void note_input(tun_in_t t);
      pending.push_back(unit_normal(t));
    endfunction

    function void check_result(tun_out_t got);
      tun_out_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.normal_x !== exp_w.normal_x || got.normal_y !== exp_w.normal_y ||
          got.normal_z !== exp_w.normal_z || got.degenerate !== exp_w.degenerate) begin
        $display("%0t: mismatch expected %h actual %h", $realtime, exp_w, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy, out_valid;
  tun_in_t in_word = '0;
  tun_out_t out_word;
  normal_board board;
  int sent;

  always #5 clk = ~clk;

  triangle_unit_normal_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  // Check every result word and note every accepted triangle
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_result(out_word);
      if (start && !busy) board.note_input(in_word);
    end
  end

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 15)) - 16'd8;
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 1023)) - 16'd512;
    endcase
  endfunction

  // Present one triangle and hold until accepted
  task automatic send_word(tun_in_t t, bit may_idle);
    if (may_idle) begin
      while ($urandom_range(0, 99) < 19) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_word <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic send_vertices(logic [15:0] ax, ay, az, bx, by, bz, cx, cy, cz);
    tun_in_t t;
    t = {ax, ay, az, bx, by, bz, cx, cy, cz};
    send_word(t, 1'b0);
  endtask

  initial begin
    tun_in_t t;
    int mode, wait_cnt;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: degenerate, axis normals, extremes, saturation-prone shapes
    send_vertices(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_vertices(16'h100, 0, 0, 0, 0, 0, 0, 16'h100, 0);
    send_vertices(0, 16'h100, 0, 0, 0, 0, 0, 0, 16'h100);
    send_vertices(0, 0, 16'h100, 0, 0, 0, 16'h100, 0, 0);
    send_vertices(0, 16'h100, 0, 0, 0, 0, 16'h100, 0, 0);
    send_vertices(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                  16'h7fff, 16'h8000, 16'h7fff);
    send_vertices(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                  16'h7fff, 16'h7fff, 16'h8000);
    send_vertices(16'h8000, 0, 0, 16'h7fff, 0, 0, 0, 16'h7fff, 16'h8000);
    send_vertices(1, 2, 3, 2, 4, 6, 3, 6, 9);
    send_vertices(1, 0, 0, 0, 0, 0, 0, 1, 0);
    send_vertices(1, 1, 0, 0, 0, 0, 1, 0, 1);
    send_vertices(16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 1, 16'hffff, 0);
    send_vertices(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                  16'h0f0f, 16'hf0f0, 16'h3c3c);
    send_vertices(16'h7fff, 0, 0, 16'h7fff, 0, 0, 16'h7fff, 0, 0);
    send_vertices(3, 0, 0, 0, 1, 0, 0, 0, 2);

    // Random: a run without idling, then idling at about 19 percent
    for (int n = 0; n < 1150; n++) begin
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 9; k++) t[k*16 +: 16] = rand_coord(mode);
      if ($urandom_range(0, 19) == 0) begin
        t.vert_c_x = t.vert_b_x;
        t.vert_c_y = t.vert_b_y;
        t.vert_c_z = t.vert_b_z;
      end
      send_word(t, n >= 300);
    end
    start <= 1'b0;

    // Drain: wait for outstanding words, then the pipeline latency
    wait_cnt = 0;
    while (board.pending.size() != 0 && wait_cnt < 2000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (80) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
